// ===== rtl/fmm_pkg.sv =====
// Shared types and constants for the single-precision matrix product engine.
// Holds the port payload structs, the command item passed through the queue and the codes.
// No dependencies.
`timescale 1ns / 1ps

package fmm_pkg;

	localparam int ROW_W      = 6;
	localparam int COL_W      = 8;
	localparam int OUT_COL_W  = 6;
	localparam int ELEM_W     = 32;
	localparam int CNT_W      = 7;
	localparam int DEPTH_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [CNT_W-1:0]   ROW_COUNT_RST = 7'd64;
	localparam logic [CNT_W-1:0]   COL_COUNT_RST = 7'd64;
	localparam logic [DEPTH_W-1:0] DEPTH_RST     = 9'd256;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

	typedef enum logic [1:0] {
		OP_WR_A    = 2'd0,
		OP_WR_B    = 2'd1,
		OP_COMPUTE = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_COUNT = 2'd0,
		CFG_COL_COUNT = 2'd1,
		CFG_DEPTH     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_WR_A,
		CMD_WR_B,
		CMD_COMPUTE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_WAIT,
		B_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ROW_W-1:0]  row_index;
		logic [COL_W-1:0]  col_index;
		logic [ELEM_W-1:0] element_bits;
	} fmm_in_t;

	typedef struct packed {
		logic [ELEM_W-1:0]    product_bits;
		logic [ROW_W-1:0]     out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic                 status;
	} fmm_out_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ELEM_W-1:0] value;
		logic              status;
		logic [DEPTH_W-1:0] len;
	} fmm_cmd_t;

endpackage

// ===== rtl/fmm_queue.sv =====
// Short command queue between the front and back parts.
// Depends on fmm_pkg for the command item type and queue depth.
`timescale 1ns / 1ps

module fmm_queue import fmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fmm_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output fmm_cmd_t pop_data
);

	fmm_cmd_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wp_q;
	logic [QPTR_W-1:0]   rp_q;
	logic [QPTR_W:0]     count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entries_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/fmm_front.sv =====
// Front part: configuration registers, item acceptance and classification.
// Depends on fmm_pkg; pushes command items into fmm_queue.
`timescale 1ns / 1ps

module fmm_front import fmm_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fmm_in_t               in_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  q_push,
	output fmm_cmd_t              q_data,
	input  logic                  q_full
);

	logic [CNT_W-1:0]   row_count_q;
	logic [CNT_W-1:0]   col_count_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               keep;
	logic               row_ok;
	logic               col_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			depth_q     <= DEPTH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data[CNT_W-1:0];
				CFG_COL_COUNT: col_count_q <= cfg_data[CNT_W-1:0];
				CFG_DEPTH:     depth_q     <= cfg_data;
				default:       ;
			endcase
		end
	end

	always_comb begin
		row_ok = (int'(in_data.row_index) < int'(row_count_q))
			&& (int'(in_data.row_index) < MAX_ROWS);
		col_ok = (int'(in_data.col_index) < int'(col_count_q))
			&& (int'(in_data.col_index) < MAX_COLS);
		q_data.row    = in_data.row_index;
		q_data.col    = in_data.col_index;
		q_data.value  = in_data.element_bits;
		q_data.status = !(row_ok && col_ok);
		q_data.len    = (int'(depth_q) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : depth_q;
		q_data.kind   = CMD_COMPUTE;
		keep          = 1'b0;
		case (in_data.opcode)
			OP_WR_A: begin
				q_data.kind = CMD_WR_A;
				keep = (int'(in_data.row_index) < MAX_ROWS)
					&& (int'(in_data.col_index) < MAX_DEPTH);
			end
			OP_WR_B: begin
				q_data.kind = CMD_WR_B;
				keep = (int'(in_data.row_index) < MAX_COLS)
					&& (int'(in_data.col_index) < MAX_DEPTH);
			end
			OP_COMPUTE: begin
				q_data.kind = CMD_COMPUTE;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

endmodule

// ===== rtl/fmm_fma.sv =====
// Nine-stage single-precision fused multiply-add, round to nearest even.
// Gradual underflow, quiet NaN output. Depends on fmm_pkg for constants.
`timescale 1ns / 1ps

module fmm_fma import fmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic        done,
	output logic [31:0] res
);

	typedef struct packed {
		logic nan;
		logic inf;
		logic inf_sign;
		logic zsign;
	} fma_flags_t;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] lzc53(input logic [52:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd53;
		found = 1'b0;
		for (int i = 52; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(52 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// stage 1: unpack, specials, mantissa product
	logic [23:0] ma, mb, mc;
	logic [9:0]  xa, xb, xc;
	logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero, p_inf;
	logic [47:0] prod;
	fma_flags_t  fl1;

	always_comb begin
		ma = {|a[30:23], a[22:0]};
		mb = {|b[30:23], b[22:0]};
		mc = {|c[30:23], c[22:0]};
		xa = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
		xb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
		xc = (c[30:23] == 8'd0) ? 10'd1 : {2'b00, c[30:23]};
		a_nan  = (&a[30:23]) && (|a[22:0]);
		b_nan  = (&b[30:23]) && (|b[22:0]);
		c_nan  = (&c[30:23]) && (|c[22:0]);
		a_inf  = (&a[30:23]) && !(|a[22:0]);
		b_inf  = (&b[30:23]) && !(|b[22:0]);
		c_inf  = (&c[30:23]) && !(|c[22:0]);
		a_zero = !(|a[30:0]);
		b_zero = !(|b[30:0]);
		c_zero = !(|c[30:0]);
		p_inf  = a_inf || b_inf;
		fl1.nan = a_nan || b_nan || c_nan || (a_inf && b_zero) || (b_inf && a_zero)
			|| (p_inf && c_inf && ((a[31] ^ b[31]) != c[31]));
		fl1.inf      = p_inf || c_inf;
		fl1.inf_sign = p_inf ? (a[31] ^ b[31]) : c[31];
		fl1.zsign    = (a_zero || b_zero) && c_zero && (a[31] ^ b[31]) && c[31];
	end

	assign prod = ma * mb;

	logic [47:0] prod_s1;
	logic [23:0] mc_s1;
	logic [9:0]  xp_s1, xc_s1;
	logic        sp_s1, sc_s1, pz_s1, cz_s1;
	fma_flags_t  fl_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		mc_s1   <= mc;
		xp_s1   <= xa + xb;
		xc_s1   <= xc + 10'd126;
		sp_s1   <= a[31] ^ b[31];
		sc_s1   <= c[31];
		pz_s1   <= a_zero || b_zero;
		cz_s1   <= c_zero;
		fl_s1   <= fl1;
	end

	// stage 2: leading zero counts
	logic [47:0] prod_s2;
	logic [23:0] mc_s2;
	logic [9:0]  xp_s2, xc_s2;
	logic [5:0]  lzp_s2, lzc_s2;
	logic        sp_s2, sc_s2, pz_s2, cz_s2;
	fma_flags_t  fl_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= prod_s1;
		mc_s2   <= mc_s1;
		xp_s2   <= xp_s1;
		xc_s2   <= xc_s1;
		lzp_s2  <= lzc48(prod_s1);
		lzc_s2  <= lzc48({mc_s1, 24'd0});
		sp_s2   <= sp_s1;
		sc_s2   <= sc_s1;
		pz_s2   <= pz_s1;
		cz_s2   <= cz_s1;
		fl_s2   <= fl_s1;
	end

	// stage 3: normalise both operands
	logic [47:0]        mp_s3, mcn_s3;
	logic signed [11:0] xp_s3, xc_s3;
	logic               sp_s3, sc_s3;
	fma_flags_t         fl_s3;

	always_ff @(posedge clk) begin
		mp_s3  <= prod_s2 << lzp_s2;
		mcn_s3 <= {mc_s2, 24'd0} << lzc_s2;
		xp_s3  <= pz_s2 ? -12'sd1024
			: $signed({2'b00, xp_s2}) - $signed({6'd0, lzp_s2});
		xc_s3  <= cz_s2 ? -12'sd1024
			: $signed({2'b00, xc_s2}) - $signed({6'd0, lzc_s2});
		sp_s3  <= sp_s2;
		sc_s3  <= sc_s2;
		fl_s3  <= fl_s2;
	end

	// stage 4: order by magnitude
	logic               p_big;
	logic signed [11:0] xdiff;

	always_comb begin
		p_big = (xp_s3 > xc_s3) || ((xp_s3 == xc_s3) && (mp_s3 >= mcn_s3));
		xdiff = p_big ? (xp_s3 - xc_s3) : (xc_s3 - xp_s3);
	end

	logic [47:0]        hi_m_s4, lo_m_s4;
	logic signed [11:0] hi_x_s4;
	logic [5:0]         d_s4;
	logic               sign_s4, sub_s4;
	fma_flags_t         fl_s4;

	always_ff @(posedge clk) begin
		hi_m_s4 <= p_big ? mp_s3 : mcn_s3;
		lo_m_s4 <= p_big ? mcn_s3 : mp_s3;
		hi_x_s4 <= p_big ? xp_s3 : xc_s3;
		d_s4    <= (xdiff > 12'sd52) ? 6'd52 : xdiff[5:0];
		sign_s4 <= p_big ? sp_s3 : sc_s3;
		sub_s4  <= sp_s3 ^ sc_s3;
		fl_s4   <= fl_s3;
	end

	// stage 5: align smaller operand, collect sticky
	logic [103:0] al_full;

	assign al_full = {lo_m_s4, 56'd0} >> d_s4;

	logic [51:0]        hi_f_s5, lo_f_s5;
	logic               stk_s5;
	logic signed [11:0] hi_x_s5;
	logic               sign_s5, sub_s5;
	fma_flags_t         fl_s5;

	always_ff @(posedge clk) begin
		hi_f_s5 <= {hi_m_s4, 4'd0};
		lo_f_s5 <= al_full[103:52];
		stk_s5  <= |al_full[51:0];
		hi_x_s5 <= hi_x_s4;
		sign_s5 <= sign_s4;
		sub_s5  <= sub_s4;
		fl_s5   <= fl_s4;
	end

	// stage 6: add or subtract, sticky kept as round-to-odd bit
	logic [52:0] sum_raw;

	assign sum_raw = sub_s5
		? ({1'b0, hi_f_s5} - {1'b0, lo_f_s5} - {52'd0, stk_s5})
		: ({1'b0, hi_f_s5} + {1'b0, lo_f_s5});

	logic [52:0]        sum_s6;
	logic signed [11:0] hi_x_s6;
	logic               sign_s6;
	fma_flags_t         fl_s6;

	always_ff @(posedge clk) begin
		sum_s6  <= sum_raw | {52'd0, stk_s5};
		hi_x_s6 <= hi_x_s5;
		sign_s6 <= sign_s5;
		fl_s6   <= fl_s5;
	end

	// stage 7: leading zero count of the sum
	logic [52:0]        sum_s7;
	logic [5:0]         lz_s7;
	logic signed [11:0] hi_x_s7;
	logic               sign_s7;
	fma_flags_t         fl_s7;

	always_ff @(posedge clk) begin
		sum_s7  <= sum_s6;
		lz_s7   <= lzc53(sum_s6);
		hi_x_s7 <= hi_x_s6;
		sign_s7 <= sign_s6;
		fl_s7   <= fl_s6;
	end

	// stage 8: normalise, exponent and rounding position
	logic signed [11:0] e_new;
	logic signed [11:0] under;
	logic [5:0]         sh_new;

	always_comb begin
		e_new = hi_x_s7 - $signed({6'd0, lz_s7}) - 12'sd125;
		under = 12'sd1 - e_new;
		if (e_new >= 12'sd1) sh_new = 6'd29;
		else if (under > 12'sd26) sh_new = 6'd55;
		else sh_new = 6'd29 + under[5:0];
	end

	logic [52:0]        sn_s8;
	logic signed [11:0] e_s8;
	logic [5:0]         sh_s8;
	logic               zero_s8;
	logic               sign_s8;
	fma_flags_t         fl_s8;

	always_ff @(posedge clk) begin
		sn_s8   <= sum_s7 << lz_s7;
		e_s8    <= e_new;
		sh_s8   <= sh_new;
		zero_s8 <= (sum_s7 == 53'd0);
		sign_s8 <= sign_s7;
		fl_s8   <= fl_s7;
	end

	// stage 9: round to nearest even and pack
	logic [107:0] rn_full;
	logic [23:0]  q24;
	logic         guard, rstk, inc;
	logic [7:0]   ebits;
	logic [30:0]  mag;
	logic [31:0]  res_new;

	always_comb begin
		rn_full = {sn_s8, 55'd0} >> sh_s8;
		q24     = rn_full[78:55];
		guard   = rn_full[54];
		rstk    = |rn_full[53:0];
		inc     = guard && (rstk || q24[0]);
		ebits   = (e_s8 >= 12'sd1) ? e_s8[7:0] : 8'd0;
		mag     = {ebits, q24[22:0]} + {30'd0, inc};
		if (fl_s8.nan) res_new = QNAN_BITS;
		else if (fl_s8.inf) res_new = {fl_s8.inf_sign, INF_MAG};
		else if (zero_s8) res_new = {fl_s8.zsign, 31'd0};
		else if (e_s8 >= 12'sd255) res_new = {sign_s8, INF_MAG};
		else res_new = {sign_s8, mag};
	end

	logic [31:0] res_s9;
	logic [8:0]  v_q;

	always_ff @(posedge clk) begin
		res_s9 <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[7:0], start};
		end
	end

	assign done = v_q[8];
	assign res  = res_s9;

endmodule

// ===== rtl/fmm_back.sv =====
// Back part: element stores, dot-product sequencer and result register.
// Depends on fmm_pkg and fmm_fma; takes command items from fmm_queue.
`timescale 1ns / 1ps

module fmm_back import fmm_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_DEPTH = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  fmm_cmd_t q_data,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output fmm_out_t out_data
);

	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_COLS * MAX_DEPTH;
	localparam int AW_A = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int AW_B = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

	logic [ELEM_W-1:0] a_mem [A_DEPTH];
	logic [ELEM_W-1:0] b_mem [B_DEPTH];

	back_state_t        state_q, state_d;
	fmm_cmd_t           cur_q;
	logic [DEPTH_W-1:0] t_q;
	logic [ELEM_W-1:0]  acc_q;
	logic [ELEM_W-1:0]  rd_a_q, rd_b_q;
	logic               rd_valid_q;
	logic               out_valid_q;
	fmm_out_t           out_q;

	logic              we_a, we_b, load_cmd, rd_en, out_load, out_free, last_step;
	logic              fma_done;
	logic [ELEM_W-1:0] fma_res;
	logic [AW_A-1:0]   wa_addr, ra_addr;
	logic [AW_B-1:0]   wb_addr, rb_addr;

	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (t_q == cur_q.len - 1'b1);

	assign wa_addr = AW_A'(int'(q_data.row) * MAX_DEPTH + int'(q_data.col));
	assign wb_addr = AW_B'(int'(q_data.row) * MAX_DEPTH + int'(q_data.col));
	assign ra_addr = AW_A'(int'(cur_q.row) * MAX_DEPTH + int'(t_q));
	assign rb_addr = AW_B'(int'(cur_q.col) * MAX_DEPTH + int'(t_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid && q_data.kind == CMD_COMPUTE) begin
					if (q_data.status || q_data.len == '0) state_d = B_DONE;
					else state_d = B_READ;
				end
			end
			B_READ:  state_d = B_WAIT;
			B_WAIT: begin
				if (fma_done) state_d = last_step ? B_DONE : B_READ;
			end
			B_DONE: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		load_cmd = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_data.kind)
						CMD_WR_A:    we_a = 1'b1;
						CMD_WR_B:    we_b = 1'b1;
						CMD_COMPUTE: load_cmd = 1'b1;
						default:     ;
					endcase
				end
			end
			B_READ:  rd_en = 1'b1;
			B_WAIT:  ;
			B_DONE:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) a_mem[wa_addr] <= q_data.value;
		if (we_b) b_mem[wb_addr] <= q_data.value;
		if (rd_en) begin
			rd_a_q <= a_mem[ra_addr];
			rd_b_q <= b_mem[rb_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) cur_q <= q_data;
		if (load_cmd) acc_q <= '0;
		else if (fma_done) acc_q <= fma_res;
		if (load_cmd) t_q <= '0;
		else if (fma_done) t_q <= t_q + 1'b1;
		if (out_load) begin
			out_q.product_bits <= acc_q;
			out_q.out_row      <= cur_q.row;
			out_q.out_col      <= cur_q.col[OUT_COL_W-1:0];
			out_q.status       <= cur_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= rd_en;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	fmm_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rd_valid_q),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.c      (acc_q),
		.done   (fma_done),
		.res    (fma_res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_start_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_q |-> state_q == B_WAIT) else $error("multiply-add started outside wait");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fma_done |-> state_q == B_WAIT) else $error("multiply-add result while not waiting");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> state_q == B_IDLE) else $error("store write during compute");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_READ |-> t_q < cur_q.len) else $error("inner index beyond length");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q) else $error("result register not loaded");

endmodule

// ===== rtl/fp32_matrix_multiply_engine.sv =====
// Top level of the single-precision matrix product engine, C = A times B-transposed.
// Depends on fmm_pkg, fmm_front, fmm_queue and fmm_back.
//
// channel  direction  handshake               payload
// in       in         in_valid / in_ready     in_data (fmm_in_t)
// out      out        out_valid / out_ready   out_data (fmm_out_t)
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A write item is stored by the back part straight from idle; a compute item runs, from
// acceptance to a valid result, a read and a wait for the nine-stage multiply-add per
// inner step; an out-of-range or zero-depth compute goes straight to the result register.
// Reset clears control state and sets the size registers to their maxima; stores are not cleared.
// The four-entry queue lets the front keep taking items while the back computes;
// out_ready low holds the result register and stalls the back part, and in_ready drops once
// the queue is full.
`timescale 1ns / 1ps

module fp32_matrix_multiply_engine import fmm_pkg::*; #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fmm_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fmm_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic     q_push, q_full, q_pop, q_valid;
	fmm_cmd_t push_cmd, pop_cmd;

	fmm_front #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_data    (push_cmd),
		.q_full    (q_full)
	);

	fmm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (pop_cmd)
	);

	fmm_back #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
